FILE: design/mtpem_pkg.sv
// ----------------------------------------------------------------------------
// mtpem_pkg
// shared types, codes and helpers of the multi-tariff pulse energy meter
// ----------------------------------------------------------------------------
package mtpem_pkg;

    localparam int COUNTER_MAX_DEF = 9999;

    localparam int CNT_ENTRIES = 5;
    localparam int CNT_AW      = 3;
    localparam int BCD_W       = 16;

    localparam logic [CNT_AW-1:0] TOTAL_IDX = 3'd4;

    localparam logic [1:0] ZONE_NIGHT   = 2'd0;
    localparam logic [1:0] ZONE_DAY     = 2'd1;
    localparam logic [1:0] ZONE_EVENING = 2'd2;
    localparam logic [1:0] ZONE_WEEKEND = 2'd3;

    localparam logic [1:0] CFG_TPS       = 2'd0;
    localparam logic [1:0] CFG_NIGHT_END = 2'd1;
    localparam logic [1:0] CFG_DAY_END   = 2'd2;
    localparam logic [1:0] CFG_MIN_HIGH  = 2'd3;

    localparam logic [7:0] TPS_RESET       = 8'd50;
    localparam logic [4:0] NIGHT_END_RESET = 5'd8;
    localparam logic [4:0] DAY_END_RESET   = 5'd16;
    localparam logic [7:0] MIN_HIGH_RESET  = 8'd1;

    localparam logic [5:0] SEC_PER_MIN    = 6'd60;
    localparam logic [5:0] MIN_PER_HOUR   = 6'd60;
    localparam logic [4:0] HOUR_PER_DAY   = 5'd24;
    localparam logic [2:0] DAY_PER_WEEK   = 3'd7;
    localparam logic [2:0] LAST_WEEKDAY   = 3'd4;
    localparam logic [2:0] FIRST_WEEKEND  = 3'd5;
    localparam logic [7:0] HIGH_TICKS_MAX = 8'd255;

    typedef struct packed {
        logic [7:0] tps;
        logic [4:0] night_end;
        logic [4:0] day_end;
        logic [7:0] min_high;
    } cfg_t;

    typedef struct packed {
        logic              bump;
        logic [CNT_AW-1:0] bump_idx;
        logic [CNT_AW-1:0] disp_idx;
    } mem_req_t;

    typedef struct packed {
        logic [1:0] active_zone;
        logic [1:0] viewed_zone;
        logic       total_mode;
        logic [1:0] power_bar;
        logic [2:0] day_now;
        logic [4:0] hour_now;
    } view_t;

    // four-digit bcd increment, ripple over the digits
    function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        logic             c;
        r = v;
        c = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            if (c)
            begin
                if (r[4*i +: 4] == 4'd9)
                begin
                    r[4*i +: 4] = 4'd0;
                end
                else
                begin
                    r[4*i +: 4] = r[4*i +: 4] + 4'd1;
                    c = 1'b0;
                end
            end
        end
        return r;
    endfunction

endpackage

FILE: design/mtpem_if.sv
// ----------------------------------------------------------------------------
// mtpem_in_if / mtpem_out_if
// valid/ready channels for ticks and display results
// ----------------------------------------------------------------------------
interface mtpem_in_if;
    logic       valid;
    logic       ready;
    logic       pulse_in;
    logic       mode_pin;
    logic       button_level;
    logic [5:0] power_level;

    modport source (output valid, pulse_in, mode_pin, button_level, power_level,
                    input ready);
    modport sink   (input valid, pulse_in, mode_pin, button_level, power_level,
                    output ready);
endinterface

interface mtpem_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  active_zone;
    logic [1:0]  viewed_zone;
    logic        total_mode;
    logic [15:0] shown_bcd;
    logic [1:0]  power_bar;
    logic [2:0]  day_now;
    logic [4:0]  hour_now;

    modport source (output valid, active_zone, viewed_zone, total_mode, shown_bcd,
                    power_bar, day_now, hour_now, input ready);
    modport sink   (input valid, active_zone, viewed_zone, total_mode, shown_bcd,
                    power_bar, day_now, hour_now, output ready);
endinterface

FILE: design/mtpem_ctrl.sv
// ----------------------------------------------------------------------------
// mtpem_ctrl
// time of day, tariff zone, view button and pulse qualifier per tick
// ----------------------------------------------------------------------------
module mtpem_ctrl
    import mtpem_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       pulse_in,
    input  logic       mode_pin,
    input  logic       button_level,
    input  logic [5:0] power_level,
    input  cfg_t       cfg,
    output mem_req_t   req,
    output view_t      view
);

    logic [7:0] tick_reg, tick_next, tick_inc;
    logic [5:0] sec_reg, sec_next, sec_inc;
    logic [5:0] min_reg, min_next, min_inc;
    logic [4:0] hour_reg, hour_next, hour_inc;
    logic [2:0] day_reg, day_next, day_inc;
    logic [1:0] zone_reg, zone_next;
    logic       phase_reg, phase_next;
    logic [7:0] ht_reg, ht_next, ht_inc;
    logic       latch_reg, latch_next;
    logic       pending_reg, pending_next;
    logic [2:0] bp_reg, bp_next, bp_inc;
    logic [1:0] vz_reg, vz_next;
    logic [3:0] bp_ext;
    logic       bump;
    logic [1:0] bar;

    assign tick_inc = tick_reg + 8'd1;
    assign sec_inc  = sec_reg + 6'd1;
    assign min_inc  = min_reg + 6'd1;
    assign hour_inc = hour_reg + 5'd1;
    assign day_inc  = day_reg + 3'd1;
    assign bp_inc   = bp_reg + 3'd1;
    assign bp_ext   = {1'b0, bp_inc} + 4'd1;
    assign ht_inc   = (ht_reg != HIGH_TICKS_MAX) ? ht_reg + 8'd1 : ht_reg;

    // clock
    always_comb
    begin
        tick_next = tick_inc;
        sec_next  = sec_reg;
        min_next  = min_reg;
        hour_next = hour_reg;
        day_next  = day_reg;
        if (tick_inc == cfg.tps)
        begin
            tick_next = '0;
            sec_next  = sec_inc;
            if (sec_inc == SEC_PER_MIN)
            begin
                sec_next = '0;
                min_next = min_inc;
                if (min_inc == MIN_PER_HOUR)
                begin
                    min_next  = '0;
                    hour_next = hour_inc;
                    if (hour_inc == HOUR_PER_DAY)
                    begin
                        hour_next = '0;
                        day_next  = (day_inc == DAY_PER_WEEK) ? 3'd0 : day_inc;
                    end
                end
            end
        end
    end

    // tariff zone, at most one switch per tick
    always_comb
    begin
        zone_next = zone_reg;
        if (min_next == 6'd0 && sec_next == 6'd0)
        begin
            case (zone_reg)
                ZONE_NIGHT:
                begin
                    if (day_next <= LAST_WEEKDAY && hour_next == cfg.night_end)
                        zone_next = ZONE_DAY;
                end
                ZONE_DAY:
                begin
                    if (day_next <= LAST_WEEKDAY && hour_next == cfg.day_end)
                        zone_next = ZONE_EVENING;
                end
                ZONE_EVENING:
                begin
                    if (hour_next == 5'd0)
                    begin
                        if (day_next >= 3'd1 && day_next <= LAST_WEEKDAY)
                            zone_next = ZONE_NIGHT;
                        else if (day_next == FIRST_WEEKEND)
                            zone_next = ZONE_WEEKEND;
                    end
                end
                default:
                begin
                    if (hour_next == 5'd0 && day_next == 3'd0)
                        zone_next = ZONE_NIGHT;
                end
            endcase
        end
    end

    // view button, press then release
    always_comb
    begin
        bp_next = bp_reg;
        vz_next = vz_reg;
        if (!latch_reg)
        begin
            if (!bp_reg[0])
            begin
                if (!button_level)
                    bp_next = bp_inc;
            end
            else if (button_level)
            begin
                bp_next = bp_inc;
                vz_next = bp_ext[2:1];
            end
        end
    end

    // pulse qualifier and mode latch
    always_comb
    begin
        phase_next   = phase_reg;
        ht_next      = ht_reg;
        latch_next   = latch_reg;
        pending_next = pending_reg;
        bump         = 1'b0;
        if (!phase_reg)
        begin
            if (pulse_in)
            begin
                ht_next = ht_inc;
                if (pending_reg)
                begin
                    latch_next   = mode_pin;
                    pending_next = 1'b0;
                end
                if (ht_inc >= cfg.min_high)
                    phase_next = 1'b1;
            end
        end
        else if (!pulse_in)
        begin
            bump       = 1'b1;
            phase_next = 1'b0;
            ht_next    = '0;
        end
    end

    always_comb
    begin
        if (power_level == 6'd0)
            bar = 2'd0;
        else if (power_level < 6'd3)
            bar = 2'd1;
        else if (power_level < 6'd6)
            bar = 2'd2;
        else
            bar = 2'd3;
    end

    assign req.bump     = bump;
    assign req.bump_idx = latch_reg ? TOTAL_IDX : {1'b0, zone_next};
    assign req.disp_idx = latch_next ? TOTAL_IDX : {1'b0, vz_next};

    assign view.active_zone = zone_next;
    assign view.viewed_zone = vz_next;
    assign view.total_mode  = latch_next;
    assign view.power_bar   = bar;
    assign view.day_now     = day_next;
    assign view.hour_now    = hour_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg    <= '0;
            sec_reg     <= '0;
            min_reg     <= '0;
            hour_reg    <= '0;
            day_reg     <= '0;
            zone_reg    <= ZONE_NIGHT;
            phase_reg   <= 1'b0;
            ht_reg      <= '0;
            latch_reg   <= 1'b0;
            pending_reg <= 1'b1;
            bp_reg      <= '0;
            vz_reg      <= '0;
        end
        else if (accept)
        begin
            tick_reg    <= tick_next;
            sec_reg     <= sec_next;
            min_reg     <= min_next;
            hour_reg    <= hour_next;
            day_reg     <= day_next;
            zone_reg    <= zone_next;
            phase_reg   <= phase_next;
            ht_reg      <= ht_next;
            latch_reg   <= latch_next;
            pending_reg <= pending_next;
            bp_reg      <= bp_next;
            vz_reg      <= vz_next;
        end
    end

`ifndef SYNTHESIS
    a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
        sec_reg < SEC_PER_MIN && min_reg < MIN_PER_HOUR
        && hour_reg < HOUR_PER_DAY && day_reg < DAY_PER_WEEK)
        else $error("clock field out of range");
    a_armed_latched: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> !pending_reg)
        else $error("pulse armed before mode latched");
`endif

endmodule

FILE: design/mtpem_cnt_mem.sv
// ----------------------------------------------------------------------------
// mtpem_cnt_mem
// energy counter memory, bcd coded, read-modify-write with write forwarding
// ----------------------------------------------------------------------------
module mtpem_cnt_mem
    import mtpem_pkg::*;
#(
    parameter int COUNTER_MAX = COUNTER_MAX_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             issue,
    input  mem_req_t         req,
    input  logic             retire,
    output logic [BCD_W-1:0] disp_bcd
);

    localparam logic [BCD_W-1:0] CMAX_BCD =
        {4'((COUNTER_MAX / 1000) % 10), 4'((COUNTER_MAX / 100) % 10),
         4'((COUNTER_MAX / 10) % 10), 4'(COUNTER_MAX % 10)};

    logic [BCD_W-1:0]       mem [CNT_ENTRIES];
    logic [CNT_ENTRIES-1:0] valid_reg;

    mem_req_t          req_reg;
    logic [BCD_W-1:0]  rd_b_reg, rd_d_reg;
    logic              vb_reg, vd_reg;
    logic              fwd_valid_reg;
    logic [CNT_AW-1:0] fwd_addr_reg;
    logic [BCD_W-1:0]  fwd_data_reg;

    logic [BCD_W-1:0] b_cur, d_cur, b_new;
    logic             wr_en;

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            req_reg  <= req;
            rd_b_reg <= mem[req.bump_idx];
            rd_d_reg <= mem[req.disp_idx];
            vb_reg   <= valid_reg[req.bump_idx];
            vd_reg   <= valid_reg[req.disp_idx];
        end
        if (wr_en)
        begin
            mem[req_reg.bump_idx] <= b_new;
            fwd_addr_reg          <= req_reg.bump_idx;
            fwd_data_reg          <= b_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            valid_reg[req_reg.bump_idx] <= 1'b1;
            fwd_valid_reg               <= 1'b1;
        end
    end

    always_comb
    begin
        if (fwd_valid_reg && fwd_addr_reg == req_reg.bump_idx)
            b_cur = fwd_data_reg;
        else
            b_cur = vb_reg ? rd_b_reg : '0;
        if (fwd_valid_reg && fwd_addr_reg == req_reg.disp_idx)
            d_cur = fwd_data_reg;
        else
            d_cur = vd_reg ? rd_d_reg : '0;
        b_new = (b_cur < CMAX_BCD) ? bcd_inc(b_cur) : b_cur;
    end

    assign wr_en    = retire && req_reg.bump;
    assign disp_bcd = (req_reg.bump && req_reg.disp_idx == req_reg.bump_idx) ? b_new : d_cur;

`ifndef SYNTHESIS
    a_fwd_capped: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> fwd_data_reg <= CMAX_BCD)
        else $error("forwarded counter above maximum");
    a_fwd_track: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> fwd_valid_reg && fwd_addr_reg == $past(req_reg.bump_idx)
        && valid_reg[$past(req_reg.bump_idx)])
        else $error("write not tracked by forwarding register");
`endif

endmodule

FILE: design/multi_tariff_pulse_energy_meter_core.sv
// stage one registers a taken tick, the output register holds its result;
// throughput: one tick per cycle while the output is not stalled; counter
// memory is read on accept, written on retire, forwarding covers the overlap
// reset: clock, zone, qualifier and button state cleared, counters read as zero
// through per-entry valid bits, configuration registers back to their defaults
// ----------------------------------------------------------------------------
// multi_tariff_pulse_energy_meter_core
// per-tick tariff energy meter: control state, counter memory, output register
// ----------------------------------------------------------------------------
module multi_tariff_pulse_energy_meter_core
    import mtpem_pkg::*;
#(
    parameter int COUNTER_MAX = COUNTER_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    mtpem_in_if.sink    in_ch,
    mtpem_out_if.source out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t             cfg_reg;
    mem_req_t         req;
    view_t            view;
    view_t            s1_view_reg;
    view_t            out_view_reg;
    logic             s1_valid_reg, s1_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic [BCD_W-1:0] out_bcd_reg;
    logic [BCD_W-1:0] disp_bcd;
    logic             accept, s1_adv, retire;

    assign s1_adv      = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !s1_valid_reg || s1_adv;
    assign accept      = in_ch.valid && in_ch.ready;
    assign retire      = s1_valid_reg && s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tps       <= TPS_RESET;
            cfg_reg.night_end <= NIGHT_END_RESET;
            cfg_reg.day_end   <= DAY_END_RESET;
            cfg_reg.min_high  <= MIN_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TPS:       cfg_reg.tps       <= cfg_data;
                CFG_NIGHT_END: cfg_reg.night_end <= cfg_data[4:0];
                CFG_DAY_END:   cfg_reg.day_end   <= cfg_data[4:0];
                CFG_MIN_HIGH:  cfg_reg.min_high  <= cfg_data;
                default:       cfg_reg.min_high  <= cfg_reg.min_high;
            endcase
        end
    end

    mtpem_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .pulse_in     (in_ch.pulse_in),
        .mode_pin     (in_ch.mode_pin),
        .button_level (in_ch.button_level),
        .power_level  (in_ch.power_level),
        .cfg          (cfg_reg),
        .req          (req),
        .view         (view)
    );

    mtpem_cnt_mem #(
        .COUNTER_MAX (COUNTER_MAX)
    ) u_cnt_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .issue    (accept),
        .req      (req),
        .retire   (retire),
        .disp_bcd (disp_bcd)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (retire)
            s1_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (retire)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_view_reg <= view;
        if (retire)
        begin
            out_view_reg <= s1_view_reg;
            out_bcd_reg  <= disp_bcd;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.active_zone = out_view_reg.active_zone;
    assign out_ch.viewed_zone = out_view_reg.viewed_zone;
    assign out_ch.total_mode  = out_view_reg.total_mode;
    assign out_ch.shown_bcd   = out_bcd_reg;
    assign out_ch.power_bar   = out_view_reg.power_bar;
    assign out_ch.day_now     = out_view_reg.day_now;
    assign out_ch.hour_now    = out_view_reg.hour_now;

`ifndef SYNTHESIS
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted transaction lost before stage one");
    a_retire_shows: assert property (@(posedge clk) disable iff (!rst_n)
        retire |=> out_valid_reg)
        else $error("retired transaction not presented");
`endif

endmodule

FILE: tb/sv/meter_reading_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_reading_checker
// watches the tick, result and register ports of the energy meter core, keeps
// its own copy of the meter clock, tariff zone, pulse qualifier, view button
// and energy counters, and compares every result against the predicted one
// ----------------------------------------------------------------------------
module meter_reading_checker
    import mtpem_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mtpem_in_if        in_mon,
    mtpem_out_if       out_mon,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         readings_waiting
);

    typedef struct packed {
        logic [1:0]  active_zone;
        logic [1:0]  viewed_zone;
        logic        total_mode;
        logic [15:0] shown_bcd;
        logic [1:0]  power_bar;
        logic [2:0]  day_now;
        logic [4:0]  hour_now;
    } reading_t;

    cfg_t        cfg;
    logic [7:0]  tick_cnt;
    logic [5:0]  sec_cnt;
    logic [5:0]  min_cnt;
    logic [4:0]  hour_cnt;
    logic [2:0]  day_cnt;
    logic [1:0]  zone;
    logic        armed;
    logic [7:0]  high_cnt;
    logic        total_latched;
    logic        mode_open;
    logic [2:0]  btn_phase;
    logic [1:0]  view;
    logic [13:0] energy [CNT_ENTRIES];
    reading_t    readings_due [$];

    function automatic reading_t meter_tick(input logic pulse, input logic mode,
                                            input logic button, input logic [5:0] power);
        reading_t          r;
        logic [CNT_AW-1:0] idx;
        int                v;

        // time of day
        tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt == cfg.tps)
        begin
            tick_cnt = '0;
            sec_cnt  = sec_cnt + 6'd1;
            if (sec_cnt == SEC_PER_MIN)
            begin
                sec_cnt = '0;
                min_cnt = min_cnt + 6'd1;
                if (min_cnt == MIN_PER_HOUR)
                begin
                    min_cnt  = '0;
                    hour_cnt = hour_cnt + 5'd1;
                    if (hour_cnt == HOUR_PER_DAY)
                    begin
                        hour_cnt = '0;
                        day_cnt  = day_cnt + 3'd1;
                        if (day_cnt == DAY_PER_WEEK)
                        begin
                            day_cnt = '0;
                        end
                    end
                end
            end
        end

        // at most one zone switch per tick, only on the exact hour
        if (min_cnt == '0 && sec_cnt == '0)
        begin
            case (zone)
                ZONE_NIGHT:
                begin
                    if (day_cnt <= LAST_WEEKDAY && hour_cnt == cfg.night_end)
                    begin
                        zone = ZONE_DAY;
                    end
                end
                ZONE_DAY:
                begin
                    if (day_cnt <= LAST_WEEKDAY && hour_cnt == cfg.day_end)
                    begin
                        zone = ZONE_EVENING;
                    end
                end
                ZONE_EVENING:
                begin
                    if (hour_cnt == '0)
                    begin
                        if (day_cnt >= 3'd1 && day_cnt <= LAST_WEEKDAY)
                        begin
                            zone = ZONE_NIGHT;
                        end
                        else if (day_cnt == FIRST_WEEKEND)
                        begin
                            zone = ZONE_WEEKEND;
                        end
                    end
                end
                default:
                begin
                    if (hour_cnt == '0 && day_cnt == '0)
                    begin
                        zone = ZONE_NIGHT;
                    end
                end
            endcase
        end

        // view button: press then release advances the viewed zone
        if (!total_latched)
        begin
            if (!btn_phase[0])
            begin
                if (!button)
                begin
                    btn_phase = btn_phase + 3'd1;
                end
            end
            else if (button)
            begin
                btn_phase = btn_phase + 3'd1;
                view      = 2'(({1'b0, btn_phase} + 4'd1) >> 1);
            end
        end

        // pulse qualifier, mode latched on the first high tick
        if (!armed)
        begin
            if (pulse)
            begin
                if (high_cnt < HIGH_TICKS_MAX)
                begin
                    high_cnt = high_cnt + 8'd1;
                end
                if (mode_open)
                begin
                    total_latched = mode;
                    mode_open     = 1'b0;
                end
                if (high_cnt >= cfg.min_high)
                begin
                    armed = 1'b1;
                end
            end
        end
        else if (!pulse)
        begin
            idx = total_latched ? TOTAL_IDX : CNT_AW'(zone);
            if (energy[idx] < COUNTER_MAX_DEF)
            begin
                energy[idx] = energy[idx] + 14'd1;
            end
            armed    = 1'b0;
            high_cnt = '0;
        end

        v = total_latched ? int'(energy[TOTAL_IDX]) : int'(energy[view]);
        if (v > 9999)
        begin
            v = 9999;
        end

        r.active_zone = zone;
        r.viewed_zone = view;
        r.total_mode  = total_latched;
        r.shown_bcd   = {4'(v / 1000), 4'((v / 100) % 10), 4'((v / 10) % 10), 4'(v % 10)};
        if (power == '0)
        begin
            r.power_bar = 2'd0;
        end
        else if (power < 6'd3)
        begin
            r.power_bar = 2'd1;
        end
        else if (power < 6'd6)
        begin
            r.power_bar = 2'd2;
        end
        else
        begin
            r.power_bar = 2'd3;
        end
        r.day_now  = day_cnt;
        r.hour_now = hour_cnt;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            cfg.tps       = TPS_RESET;
            cfg.night_end = NIGHT_END_RESET;
            cfg.day_end   = DAY_END_RESET;
            cfg.min_high  = MIN_HIGH_RESET;
            tick_cnt      = '0;
            sec_cnt       = '0;
            min_cnt       = '0;
            hour_cnt      = '0;
            day_cnt       = '0;
            zone          = ZONE_NIGHT;
            armed         = 1'b0;
            high_cnt      = '0;
            total_latched = 1'b0;
            mode_open     = 1'b1;
            btn_phase     = '0;
            view          = '0;
            for (int i = 0; i < CNT_ENTRIES; i++)
            begin
                energy[i] = '0;
            end
            readings_due.delete();
            fail_count       = 0;
            readings_waiting <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TPS:       cfg.tps       = cfg_data;
                    CFG_NIGHT_END: cfg.night_end = cfg_data[4:0];
                    CFG_DAY_END:   cfg.day_end   = cfg_data[4:0];
                    CFG_MIN_HIGH:  cfg.min_high  = cfg_data;
                    default:       ;
                endcase
            end

            if (out_mon.valid && out_mon.ready)
            begin
                if (readings_due.size() == 0)
                begin
                    $error("result transaction with no expected reading");
                    fail_count++;
                end
                else
                begin
                    want = readings_due.pop_front();
                    compare_field("active_zone", 16'(want.active_zone), 16'(out_mon.active_zone));
                    compare_field("viewed_zone", 16'(want.viewed_zone), 16'(out_mon.viewed_zone));
                    compare_field("total_mode", 16'(want.total_mode), 16'(out_mon.total_mode));
                    compare_field("shown_bcd", want.shown_bcd, out_mon.shown_bcd);
                    compare_field("power_bar", 16'(want.power_bar), 16'(out_mon.power_bar));
                    compare_field("day_now", 16'(want.day_now), 16'(out_mon.day_now));
                    compare_field("hour_now", 16'(want.hour_now), 16'(out_mon.hour_now));
                end
            end

            if (in_mon.valid && in_mon.ready)
            begin
                readings_due.push_back(meter_tick(in_mon.pulse_in, in_mon.mode_pin,
                                                  in_mon.button_level, in_mon.power_level));
            end

            readings_waiting <= readings_due.size();
        end
    end

endmodule

FILE: tb/sv/multi_tariff_pulse_energy_meter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_tariff_pulse_energy_meter_core_tb
// drives ticks and register writes into the energy meter core: a directed
// opening, random pulse and button trains under several settings with random
// idling and a long output hold-off, then a stretch of one-tick seconds with
// no idling on either side
// ----------------------------------------------------------------------------
module multi_tariff_pulse_energy_meter_core_tb;
    import mtpem_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 6;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int NO_IDLE_TICKS = 200;
    localparam int CYCLE_LIMIT = 50000;

    typedef struct packed {
        logic       pulse;
        logic       mode;
        logic       button;
        logic [5:0] power;
    } tick_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    int         fail_count;
    int         readings_waiting;
    int         cycles = 0;
    logic       tx_idling;
    logic       rx_idling;
    logic       hold_req;

    logic       train_level;
    int         train_left;
    int         high_max;
    logic       btn_level;
    int         btn_left;

    mtpem_in_if  in_ch ();
    mtpem_out_if out_ch ();

    multi_tariff_pulse_energy_meter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    meter_reading_checker reading_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_mon           (in_ch),
        .out_mon          (out_ch),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .readings_waiting (readings_waiting)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("multi_tariff_pulse_energy_meter_core: mismatch");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        logic hold_done;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_idling)
            begin
                out_ch.ready <= ($urandom_range(0, 99) >= 21);
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic write_settings(input logic [7:0] tps, input logic [4:0] night_end,
                                  input logic [4:0] day_end, input logic [7:0] min_high);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TPS;
        cfg_data  <= tps;
        @(posedge clk);
        cfg_index <= CFG_NIGHT_END;
        cfg_data  <= {3'b000, night_end};
        @(posedge clk);
        cfg_index <= CFG_DAY_END;
        cfg_data  <= {3'b000, day_end};
        @(posedge clk);
        cfg_index <= CFG_MIN_HIGH;
        cfg_data  <= min_high;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic drive_tick(input logic pulse, input logic mode, input logic button,
                              input logic [5:0] power);
        while (tx_idling && $urandom_range(0, 99) < 21)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.pulse_in     <= pulse;
        in_ch.mode_pin     <= mode;
        in_ch.button_level <= button;
        in_ch.power_level  <= power;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // well-formed pulse and button trains with some noise on the pulse line
    function automatic tick_t make_tick();
        tick_t t;
        if (train_left == 0)
        begin
            train_level = !train_level;
            train_left  = train_level ? $urandom_range(1, high_max) : $urandom_range(1, 3);
        end
        train_left = train_left - 1;
        if (btn_left == 0)
        begin
            btn_level = !btn_level;
            btn_left  = btn_level ? $urandom_range(5, 60) : $urandom_range(1, 4);
        end
        btn_left = btn_left - 1;
        t.pulse  = ($urandom_range(0, 99) < 8) ? 1'($urandom_range(0, 1)) : train_level;
        t.mode   = 1'($urandom_range(0, 1));
        t.button = btn_level;
        t.power  = ($urandom_range(0, 1) == 1) ? 6'($urandom_range(0, 7))
                                                : 6'($urandom_range(0, 63));
        return t;
    endfunction

    task automatic run_ticks(input int count);
        tick_t t;
        for (int i = 0; i < count; i++)
        begin
            t = make_tick();
            drive_tick(t.pulse, t.mode, t.button, t.power);
        end
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (readings_waiting != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic mode_sel;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_TPS;
        cfg_data           <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.pulse_in     <= 1'b0;
        in_ch.mode_pin     <= 1'b0;
        in_ch.button_level <= 1'b1;
        in_ch.power_level  <= '0;
        rx_idling          <= 1'b1;
        hold_req           <= 1'b0;
        tx_idling   = 1'b1;
        train_level = 1'b0;
        train_left  = 0;
        high_max    = 4;
        btn_level   = 1'b0;
        btn_left    = 0;
        mode_sel    = 1'($urandom_range(0, 1));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // both hour registers at zero: night, day and evening on successive ticks
        write_settings(TPS_RESET, 5'd0, 5'd0, 8'd0);
        drive_tick(1'b0, !mode_sel, 1'b1, 6'd0);
        drive_tick(1'b0, !mode_sel, 1'b0, 6'd1);
        drive_tick(1'b0, mode_sel, 1'b1, 6'd2);
        // first high tick latches the mode, zero minimum arms at once
        drive_tick(1'b1, mode_sel, 1'b1, 6'd3);
        drive_tick(1'b0, !mode_sel, 1'b1, 6'd5);
        drive_tick(1'b1, !mode_sel, 1'b0, 6'd6);
        drive_tick(1'b1, mode_sel, 1'b1, 6'd63);
        drive_tick(1'b0, 1'b0, 1'b0, 6'd4);
        drive_tick(1'b0, 1'b1, 1'b1, 6'd62);
        drive_tick(1'b0, 1'b0, 1'b0, 6'd7);
        drive_tick(1'b0, 1'b0, 1'b1, 6'd8);
        drive_tick(1'b0, 1'b1, 1'b0, 6'd0);
        drive_tick(1'b0, 1'b1, 1'b1, 6'd63);
        drive_tick(1'b1, 1'b0, 1'b0, 6'd1);
        drive_tick(1'b0, 1'b1, 1'b0, 6'd2);
        drive_tick(1'b0, 1'b0, 1'b1, 6'd42);
        settle();

        // one tick per second, hour registers out of range
        write_settings(8'd1, 5'd31, 5'd31, 8'd1);
        run_ticks(250);
        settle();

        // 256 ticks per second, maximum qualifier length, long result hold-off
        high_max = 40;
        write_settings(8'd0, 5'd23, 5'd0, 8'd255);
        hold_req <= 1'b1;
        run_ticks(250);
        settle();

        // tps setting of 255, sender pause in the middle
        high_max = 6;
        write_settings(8'd255, 5'd5, 5'd17, 8'd3);
        run_ticks(125);
        settle();
        run_ticks(125);
        settle();

        high_max = 10;
        write_settings(8'($urandom_range(1, 255)), 5'($urandom_range(0, 31)),
                       5'($urandom_range(0, 31)), 8'($urandom_range(1, 8)));
        run_ticks(100);
        settle();

        // one tick per second, no idling on either side
        tx_idling = 1'b0;
        rx_idling <= 1'b0;
        high_max  = 3;
        write_settings(8'd1, 5'd0, 5'd23, 8'd2);
        run_ticks(NO_IDLE_TICKS);
        settle();

        if (fail_count == 0)
        begin
            $display("multi_tariff_pulse_energy_meter_core: match");
        end
        else
        begin
            $display("multi_tariff_pulse_energy_meter_core: mismatch");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/mtpem_pkg.sv
design/mtpem_if.sv
design/mtpem_ctrl.sv
design/mtpem_cnt_mem.sv
design/multi_tariff_pulse_energy_meter_core.sv
tb/sv/meter_reading_checker.sv
tb/sv/multi_tariff_pulse_energy_meter_core_tb.sv
